[hdl/ppst_pkg.sv]
// Shared types, constants and the palette table of the planar pixel store.
// Used by every module of the block; depends on nothing else.
package ppst_pkg;

   localparam int PLANE_DEPTH  = 65536;
   localparam int ADDR_W       = $clog2(PLANE_DEPTH);
   localparam int PLANE_COUNT  = 4;
   localparam int PLANE_BYTE_W = 8;
   localparam int WORD_W       = 32;

   localparam int X_W      = 10;
   localparam int Y_W      = 10;
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 10;
   localparam int STRIDE_W = WIDTH_W - 3;
   localparam int OFF_W    = Y_W + STRIDE_W + 1;
   localparam int BIT_W    = $clog2(PLANE_BYTE_W);

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(350);

   localparam logic CSR_WIDTH_IDX  = 1'b0;
   localparam logic CSR_HEIGHT_IDX = 1'b1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   localparam logic [7:0] LVL_OFF = 8'h00;
   localparam logic [7:0] LVL_LO  = 8'h55;
   localparam logic [7:0] LVL_MID = 8'hAA;
   localparam logic [7:0] LVL_HI  = 8'hFF;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS
   } state_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      logic              in_range;
      logic [ADDR_W-1:0] offset;
   } addr_chk_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } mem_wr_type;

   function automatic rgb_type palette(input logic [PLANE_COUNT-1:0] idx);
      rgb_type c;
      unique case (idx)
         4'd0:    c = '{LVL_OFF, LVL_OFF, LVL_OFF};
         4'd1:    c = '{LVL_OFF, LVL_OFF, LVL_MID};
         4'd2:    c = '{LVL_OFF, LVL_MID, LVL_OFF};
         4'd3:    c = '{LVL_OFF, LVL_MID, LVL_MID};
         4'd4:    c = '{LVL_MID, LVL_OFF, LVL_OFF};
         4'd5:    c = '{LVL_MID, LVL_OFF, LVL_MID};
         4'd6:    c = '{LVL_MID, LVL_LO,  LVL_OFF};
         4'd7:    c = '{LVL_MID, LVL_MID, LVL_MID};
         4'd8:    c = '{LVL_LO,  LVL_LO,  LVL_LO};
         4'd9:    c = '{LVL_LO,  LVL_LO,  LVL_HI};
         4'd10:   c = '{LVL_LO,  LVL_HI,  LVL_LO};
         4'd11:   c = '{LVL_LO,  LVL_HI,  LVL_HI};
         4'd12:   c = '{LVL_HI,  LVL_LO,  LVL_LO};
         4'd13:   c = '{LVL_HI,  LVL_LO,  LVL_HI};
         4'd14:   c = '{LVL_HI,  LVL_HI,  LVL_LO};
         default: c = '{LVL_HI,  LVL_HI,  LVL_HI};
      endcase
      return c;
   endfunction

endpackage

[hdl/ppst_addr.sv]
// Coordinate check and byte offset of the planar pixel store.
// Depends on ppst_pkg for widths and the address check struct.
module ppst_addr (
   input  logic [ppst_pkg::X_W-1:0]      x_pos,
   input  logic [ppst_pkg::Y_W-1:0]      y_pos,
   input  logic [ppst_pkg::WIDTH_W-1:0]  width_pixels,
   input  logic [ppst_pkg::HEIGHT_W-1:0] height_lines,
   output ppst_pkg::addr_chk_type        chk
);

   logic [ppst_pkg::STRIDE_W-1:0] stride;
   logic [ppst_pkg::OFF_W-1:0]    offset;
   logic                          coord_ok;

   // A width that is not a multiple of eight rounds the stride down.
   assign stride = width_pixels[ppst_pkg::WIDTH_W-1:3];

   assign offset = ppst_pkg::OFF_W'(y_pos) * ppst_pkg::OFF_W'(stride)
                 + ppst_pkg::OFF_W'(x_pos[ppst_pkg::X_W-1:3]);

   assign coord_ok = (ppst_pkg::WIDTH_W'(x_pos) < width_pixels)
                  && (ppst_pkg::HEIGHT_W'(y_pos) < height_lines);

   assign chk.in_range = coord_ok
                      && (offset < ppst_pkg::OFF_W'(ppst_pkg::PLANE_DEPTH));
   assign chk.offset   = offset[ppst_pkg::ADDR_W-1:0];

endmodule

[hdl/ppst_plane_mem.sv]
// Plane memory: one 32-bit word per byte offset, one plane per byte lane.
// One write and one registered read per cycle; depends on ppst_pkg.
module ppst_plane_mem (
   input  logic                          clock,
   input  ppst_pkg::mem_wr_type          wr,
   input  logic                          rd_en,
   input  logic [ppst_pkg::ADDR_W-1:0]   rd_addr,
   output logic [ppst_pkg::WORD_W-1:0]   rd_data
);

   logic [ppst_pkg::WORD_W-1:0] mem [ppst_pkg::PLANE_DEPTH];
   logic [ppst_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/planar_pixel_store_top.sv]
// Four-plane planar pixel store: a request is registered and its word read; the access
// state writes it back or gathers the pixel, and the result is registered. A new request
// waits for the access state to end (single memory read-modify-write). After reset the
// memory is cleared one word a cycle, busy high; register writes are taken meanwhile.
// Depends on ppst_pkg, ppst_addr and ppst_plane_mem.
module planar_pixel_store_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [ppst_pkg::X_W-1:0]      req_x_pos,
   input  logic [ppst_pkg::Y_W-1:0]      req_y_pos,
   input  logic [ppst_pkg::PLANE_COUNT-1:0] req_color_index,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [ppst_pkg::WIDTH_W-1:0]  csr_wdata,
   output logic                          rsp_valid,
   output logic                          rsp_status,
   output logic [ppst_pkg::PLANE_COUNT-1:0] rsp_read_index,
   output logic [7:0]                    rsp_red,
   output logic [7:0]                    rsp_green,
   output logic [7:0]                    rsp_blue
);

   ppst_pkg::state_type state_ff, state_in;
   logic [ppst_pkg::ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [ppst_pkg::WIDTH_W-1:0]  width_ff;
   logic [ppst_pkg::HEIGHT_W-1:0] height_ff;

   logic                             cmd_ff;
   logic [ppst_pkg::PLANE_COUNT-1:0] color_ff;
   logic [ppst_pkg::BIT_W-1:0]       bitpos_ff;
   logic                             ok_ff;
   logic [ppst_pkg::ADDR_W-1:0]      offset_ff;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_status_ff, rsp_status_in;
   logic [ppst_pkg::PLANE_COUNT-1:0] rsp_index_ff, rsp_index_in;
   ppst_pkg::rgb_type                rsp_rgb_ff, rsp_rgb_in;

   ppst_pkg::addr_chk_type           chk;
   ppst_pkg::mem_wr_type             mem_wr;
   logic                             accept;
   logic                             clr_last;
   logic [ppst_pkg::WORD_W-1:0]      rd_word;
   logic [ppst_pkg::WORD_W-1:0]      mod_word;
   logic [ppst_pkg::PLANE_COUNT-1:0] gathered;

   ppst_addr u_addr (
      .x_pos        (req_x_pos),
      .y_pos        (req_y_pos),
      .width_pixels (width_ff),
      .height_lines (height_ff),
      .chk          (chk)
   );

   ppst_plane_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_en   (accept),
      .rd_addr (chk.offset),
      .rd_data (rd_word)
   );

   assign accept   = start && !busy;
   assign clr_last = (clr_addr_ff == ppst_pkg::ADDR_W'(ppst_pkg::PLANE_DEPTH - 1));

   // The pixel bit within each plane byte: x mod 8 counts from the top bit.
   always_comb begin
      mod_word = rd_word;
      gathered = '0;
      for (int n = 0; n < ppst_pkg::PLANE_COUNT; n++) begin
         mod_word[n*ppst_pkg::PLANE_BYTE_W + bitpos_ff] = color_ff[n];
         gathered[n] = rd_word[n*ppst_pkg::PLANE_BYTE_W + bitpos_ff];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppst_pkg::ST_CLEAR:  if (clr_last) state_in = ppst_pkg::ST_IDLE;
         ppst_pkg::ST_IDLE:   if (start)    state_in = ppst_pkg::ST_ACCESS;
         ppst_pkg::ST_ACCESS: state_in = ppst_pkg::ST_IDLE;
         default:             state_in = ppst_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      busy          = 1'b1;
      clr_addr_in   = clr_addr_ff;
      mem_wr.we     = 1'b0;
      mem_wr.addr   = offset_ff;
      mem_wr.data   = mod_word;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ppst_pkg::STATUS_DONE;
      rsp_index_in  = '0;
      rsp_rgb_in    = '0;
      unique case (state_ff)
         ppst_pkg::ST_CLEAR: begin
            mem_wr.we   = 1'b1;
            mem_wr.addr = clr_addr_ff;
            mem_wr.data = '0;
            clr_addr_in = clr_addr_ff + ppst_pkg::ADDR_W'(1);
         end
         ppst_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         ppst_pkg::ST_ACCESS: begin
            rsp_valid_in = 1'b1;
            if (!ok_ff) begin
               rsp_status_in = ppst_pkg::STATUS_RANGE;
            end else if (cmd_ff == ppst_pkg::CMD_WRITE) begin
               mem_wr.we = 1'b1;
            end else begin
               rsp_index_in = gathered;
               rsp_rgb_in   = ppst_pkg::palette(gathered);
            end
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppst_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ppst_pkg::WIDTH_RESET;
         height_ff <= ppst_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ppst_pkg::CSR_WIDTH_IDX:  width_ff  <= csr_wdata;
            ppst_pkg::CSR_HEIGHT_IDX: height_ff <= csr_wdata[ppst_pkg::HEIGHT_W-1:0];
            default:                  width_ff  <= width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_command;
         color_ff  <= req_color_index;
         bitpos_ff <= ~req_x_pos[ppst_pkg::BIT_W-1:0];
         ok_ff     <= chk.in_range;
         offset_ff <= chk.offset;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_rgb_ff    <= rsp_rgb_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_index = rsp_index_ff;
   assign rsp_red        = rsp_rgb_ff.red;
   assign rsp_green      = rsp_rgb_ff.green;
   assign rsp_blue       = rsp_rgb_ff.blue;

   // Every accepted request produces its response, registered after the access state.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("accepted request produced no response");

   // A response only comes out of the access cycle.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ppst_pkg::ST_ACCESS)
      else $error("response without an access cycle");

   // The read-modify-write interlock: no request is taken during write-back.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy ##1 !busy)
      else $error("request overlapped a memory access");

   // The clearing pass never mixes with requests or responses.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ppst_pkg::ST_CLEAR |-> busy && !rsp_valid)
      else $error("activity during the clearing pass");

endmodule
